/* rtl/core/mtm_pkg.sv */
// ============================================================================
// MUS to MIDI transcoder package
// Shared types, codes and the controller translation table.
// ============================================================================
package mtm_pkg;

    // Parse phase of the score byte stream.
    typedef enum logic [3:0] {
        PH_DESC   = 4'd0,
        PH_KREL   = 4'd1,
        PH_KPRESS = 4'd2,
        PH_VEL    = 4'd3,
        PH_PITCH  = 4'd4,
        PH_SYS    = 4'd5,
        PH_CNUM   = 4'd6,
        PH_CVAL   = 4'd7,
        PH_DELAY  = 4'd8,
        PH_DONE   = 4'd9
    } t_phase;

    // Top-level control sequence for one input word.
    typedef enum logic [1:0] {
        C_IDLE,
        C_EVAL,
        C_EMIT
    } t_ctl;

    // Byte position inside one emitted event.
    typedef enum logic [2:0] {
        S_IDLE,
        S_TIME,
        S_STAT,
        S_D1,
        S_D2,
        S_ERR
    } t_sub;

    // One MIDI event: status and data bytes, program change has one data byte.
    typedef struct packed {
        logic [7:0] status;
        logic [7:0] d1;
        logic [7:0] d2;
        logic       one_data;
    } t_event;

    // Everything one input word asks the emitter to send.
    typedef struct packed {
        t_event [2:0] ev;
        logic [1:0]   nev;
        logic         err;
        logic         done;
    } t_plan;

    localparam logic [27:0] TIME_MAX   = 28'hFFF_FFFF;
    localparam logic [27:0] ACC_LIMIT  = 28'h01F_FFFF;
    localparam logic [3:0]  MUS_PERC   = 4'd15;
    localparam logic [3:0]  MIDI_PERC  = 4'd9;
    localparam logic [4:0]  NONE_ALLOC = 5'h1F;

    localparam logic [3:0]  EV_REL   = 4'd0;
    localparam logic [3:0]  EV_PRESS = 4'd1;
    localparam logic [3:0]  EV_PITCH = 4'd2;
    localparam logic [3:0]  EV_SYS   = 4'd3;
    localparam logic [3:0]  EV_CTL   = 4'd4;
    localparam logic [3:0]  EV_END   = 4'd6;

    localparam logic [7:0]  ST_OFF   = 8'h80;
    localparam logic [7:0]  ST_ON    = 8'h90;
    localparam logic [7:0]  ST_CTL   = 8'hB0;
    localparam logic [7:0]  ST_PROG  = 8'hC0;
    localparam logic [7:0]  ST_BEND  = 8'hE0;
    localparam logic [7:0]  ST_META  = 8'hFF;
    localparam logic [7:0]  META_EOT = 8'h2F;

    localparam logic [7:0]  CC_SOUND_OFF = 8'h78;
    localparam logic [7:0]  CC_NOTES_OFF = 8'h7B;
    localparam logic [7:0]  CC_PAN       = 8'h0A;
    localparam logic [7:0]  MID_VALUE    = 8'h40;

    localparam logic [7:0]  SYS_LOW   = 8'd10;
    localparam logic [7:0]  SYS_HIGH  = 8'd14;
    localparam logic [7:0]  SYS_RESET = 8'd14;
    localparam logic [7:0]  CTL_HIGH  = 8'd9;

    // MUS controller / system number to MIDI controller number.
    function automatic logic [7:0] ctl_map(input logic [3:0] num);
        logic [7:0] r;
        case (num)
            4'd0:    r = 8'h00;
            4'd1:    r = 8'h20;
            4'd2:    r = 8'h01;
            4'd3:    r = 8'h07;
            4'd4:    r = 8'h0A;
            4'd5:    r = 8'h0B;
            4'd6:    r = 8'h5B;
            4'd7:    r = 8'h5D;
            4'd8:    r = 8'h40;
            4'd9:    r = 8'h43;
            4'd10:   r = 8'h78;
            4'd11:   r = 8'h7B;
            4'd12:   r = 8'h7E;
            4'd13:   r = 8'h7F;
            4'd14:   r = 8'h79;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic t_event mk_ev(input logic [7:0] s, input logic [7:0] a,
                                     input logic [7:0] b, input logic one);
        t_event e;
        e.status   = s;
        e.d1       = a;
        e.d2       = b;
        e.one_data = one;
        return e;
    endfunction

endpackage

/* rtl/core/mtm_chan_mem.sv */
// ============================================================================
// Channel state memories
// Channel assignment and per-channel velocity, each a 16-entry synchronous
// memory with registered read data and per-entry valid bits.
// ============================================================================
module mtm_chan_mem
    import mtm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_clear,
    input  logic       i_rd_en,
    input  logic [3:0] i_asg_raddr,
    input  logic [3:0] i_vel_raddr,
    input  logic       i_asg_we,
    input  logic [3:0] i_asg_waddr,
    input  logic [3:0] i_asg_wdata,
    input  logic       i_vel_we,
    input  logic [3:0] i_vel_waddr,
    input  logic [6:0] i_vel_wdata,
    output logic       o_asg_hit,
    output logic [3:0] o_asg_rdata,
    output logic [6:0] o_vel_rdata
);

    logic [3:0]  r_asg_mem [16];
    logic [6:0]  r_vel_mem [16];
    logic [15:0] r_asg_vld;
    logic [15:0] r_vel_vld;
    logic        r_asg_hit;
    logic [3:0]  r_asg_q;
    logic        r_vel_hit;
    logic [6:0]  r_vel_q;

    // Storage writes.
    always_ff @(posedge i_clk) begin
        if (i_asg_we) begin
            r_asg_mem[i_asg_waddr] <= i_asg_wdata;
        end
        if (i_vel_we) begin
            r_vel_mem[i_vel_waddr] <= i_vel_wdata;
        end
    end

    // Valid bits: assignment clears per score, velocity only on reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_asg_vld <= '0;
            r_vel_vld <= '0;
        end else begin
            if (i_clear) begin
                r_asg_vld <= '0;
            end else if (i_asg_we) begin
                r_asg_vld[i_asg_waddr] <= 1'b1;
            end
            if (i_vel_we) begin
                r_vel_vld[i_vel_waddr] <= 1'b1;
            end
        end
    end

    // Registered reads; a clear in the same cycle hides old assignments.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_asg_q   <= r_asg_mem[i_asg_raddr];
            r_asg_hit <= r_asg_vld[i_asg_raddr] & ~i_clear;
            r_vel_q   <= r_vel_mem[i_vel_raddr];
            r_vel_hit <= r_vel_vld[i_vel_raddr];
        end
    end

    assign o_asg_hit   = r_asg_hit;
    assign o_asg_rdata = r_asg_q;
    assign o_vel_rdata = r_vel_hit ? r_vel_q : 7'h7F;

endmodule

/* rtl/core/mtm_emitter.sv */
// ============================================================================
// MIDI byte emitter
// Walks a plan of up to three events; sends delta time, status and data bytes
// one per unstalled cycle to the output register, then an error word if asked.
// ============================================================================
module mtm_emitter
    import mtm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_clear,
    input  logic        i_start,
    input  t_plan       i_plan,
    input  logic [27:0] i_pend,
    output logic        o_busy,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_midi_byte,
    output logic        o_last,
    output logic        o_bad_score,
    output logic        o_score_done,
    output logic [31:0] o_track_length
);

    t_sub        r_sub;
    t_sub        n_sub;
    t_plan       r_plan;
    logic [1:0]  r_idx;
    logic [1:0]  r_tg;
    logic [27:0] r_t;
    logic [31:0] r_cnt;
    logic        r_ov;
    logic [7:0]  r_byte;
    logic        r_last;
    logic        r_bad;
    logic        r_done;
    logic [31:0] r_len;

    t_event      cur;
    logic        adv;
    logic        final_ev;
    logic        ev_end;
    logic [7:0]  byte_out;
    logic [6:0]  tslice;
    logic [1:0]  groups;
    logic        out_last;

    assign cur      = r_plan.ev[r_idx];
    assign adv      = (r_sub != S_IDLE) && (!r_ov || !i_stall);
    assign final_ev = (r_idx == (r_plan.nev - 2'd1));
    assign o_busy   = (r_sub != S_IDLE);

    // Number of 7-bit delta time groups, minus one.
    always_comb begin
        if (i_pend[27:21] != 7'd0) begin
            groups = 2'd3;
        end else if (i_pend[20:14] != 7'd0) begin
            groups = 2'd2;
        end else if (i_pend[13:7] != 7'd0) begin
            groups = 2'd1;
        end else begin
            groups = 2'd0;
        end
    end

    // Current delta time group.
    always_comb begin
        case (r_tg)
            2'd0:    tslice = r_t[6:0];
            2'd1:    tslice = r_t[13:7];
            2'd2:    tslice = r_t[20:14];
            2'd3:    tslice = r_t[27:21];
            default: tslice = r_t[6:0];
        endcase
    end

    // Byte selection, end of event and next position.
    always_comb begin
        n_sub    = r_sub;
        byte_out = 8'h00;
        ev_end   = 1'b0;
        case (r_sub)
            S_IDLE: begin
                if (i_start) begin
                    n_sub = (i_plan.nev == 2'd0) ? S_ERR : S_TIME;
                end
            end
            S_TIME: begin
                byte_out = {(r_tg != 2'd0), tslice};
                if (r_tg == 2'd0) begin
                    n_sub = S_STAT;
                end
            end
            S_STAT: begin
                byte_out = cur.status;
                n_sub    = S_D1;
            end
            S_D1: begin
                byte_out = cur.d1;
                ev_end   = cur.one_data;
                n_sub    = S_D2;
            end
            S_D2: begin
                byte_out = cur.d2;
                ev_end   = 1'b1;
            end
            S_ERR: begin
                n_sub = S_IDLE;
            end
            default: n_sub = S_IDLE;
        endcase
        if (ev_end) begin
            if (!final_ev) begin
                n_sub = S_TIME;
            end else if (r_plan.err) begin
                n_sub = S_ERR;
            end else begin
                n_sub = S_IDLE;
            end
        end
        if ((r_sub != S_IDLE) && !adv) begin
            n_sub = r_sub;
        end
    end

    assign out_last = (ev_end && final_ev && !r_plan.err) || (r_sub == S_ERR);

    // Position register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub <= S_IDLE;
        end else begin
            r_sub <= n_sub;
        end
    end

    // Plan, event index and delta time; time is spent by the first event.
    always_ff @(posedge i_clk) begin
        if (r_sub == S_IDLE && i_start) begin
            r_plan <= i_plan;
            r_idx  <= 2'd0;
            r_t    <= i_pend;
            r_tg   <= groups;
        end else if (adv) begin
            if (r_sub == S_TIME && r_tg != 2'd0) begin
                r_tg <= r_tg - 2'd1;
            end
            if (ev_end && !final_ev) begin
                r_idx <= r_idx + 2'd1;
                r_t   <= '0;
                r_tg  <= 2'd0;
            end
        end
    end

    // Track byte count; the error word is not counted.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_clear) begin
            r_cnt <= '0;
        end else if (adv && r_sub != S_ERR) begin
            r_cnt <= r_cnt + 32'd1;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (adv) begin
            r_ov <= 1'b1;
        end else if (!i_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_byte <= byte_out;
            r_last <= out_last;
            r_bad  <= (r_sub == S_ERR);
            r_done <= r_plan.done;
            r_len  <= (r_sub == S_ERR) ? r_cnt : (r_cnt + 32'd1);
        end
    end

    assign o_valid        = r_ov;
    assign o_midi_byte    = r_byte;
    assign o_last         = r_last;
    assign o_bad_score    = r_bad;
    assign o_score_done   = r_done;
    assign o_track_length = r_len;

`ifndef ASSERT_OFF
    // The error word always closes the burst.
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_bad) |-> r_last)
        else $error("error word without last flag");

    // A new plan only arrives while the emitter is free.
    a_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_sub == S_IDLE))
        else $error("plan started while emitter busy");

    // A word sent while the output was free appears in the register.
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> r_ov)
        else $error("emitted byte lost");
`endif

endmodule

/* rtl/core/mus_to_midi_event_transcoder.sv */
// ============================================================================
// MUS to MIDI event transcoder
// Parses MUS score body bytes and produces MIDI track bytes.
// ============================================================================
// One score byte is taken and its channel state is read from the channel
// memories as it is taken; it is evaluated in the next cycle, and the MIDI
// bytes that result then leave at one per cycle through the output register
// while the output side does not stall. A byte may produce no result words
// (delay, controller-number and ignored bytes among them) or n result words,
// n being 1 to 15. No new score byte is taken until the emitter has handed
// the last result word of the previous byte to the output register.
module mus_to_midi_event_transcoder
    import mtm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_score_byte,
    input  logic        i_new_score,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_midi_byte,
    output logic        o_last,
    output logic        o_bad_score,
    output logic        o_score_done,
    output logic [31:0] o_track_length
);

    t_ctl        r_state;
    t_ctl        n_state;
    t_phase      r_phase;
    t_phase      n_phase;
    logic [3:0]  r_cur_ch;
    logic [3:0]  n_cur_ch;
    logic        r_ge;
    logic        n_ge;
    logic [7:0]  r_key;
    logic [7:0]  n_key;
    logic [7:0]  r_ctl;
    logic [7:0]  n_ctl;
    logic [27:0] r_acc;
    logic [27:0] n_acc;
    logic [27:0] r_pend;
    logic [27:0] n_pend;
    logic [4:0]  r_best;
    logic [4:0]  n_best;
    logic        r_halt;
    logic        n_halt;
    logic        r_adlib;
    logic [7:0]  r_byte;

    logic        accept;
    logic        clear;
    logic        eval;
    logic        asg_hit;
    logic [3:0]  asg_rdata;
    logic [6:0]  vel_rdata;
    logic        asg_we;
    logic        vel_we;
    logic [4:0]  alloc_ch;
    logic        start;
    logic        emit_busy;
    t_plan       plan;
    logic [28:0] pend_sum;
    logic [27:0] acc_next;
    logic [7:0]  cval;

    assign accept = i_in_valid && !o_in_stall;
    assign clear  = accept && i_new_score;
    assign eval   = (r_state == C_EVAL) && !r_halt;
    assign o_in_stall = (r_state != C_IDLE);

    mtm_chan_mem u_mem (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear     (clear),
        .i_rd_en     (accept),
        .i_asg_raddr (i_score_byte[3:0]),
        .i_vel_raddr (r_cur_ch),
        .i_asg_we    (asg_we),
        .i_asg_waddr (r_byte[3:0]),
        .i_asg_wdata (alloc_ch[3:0]),
        .i_vel_we    (vel_we),
        .i_vel_waddr (r_cur_ch),
        .i_vel_wdata (r_byte[6:0]),
        .o_asg_hit   (asg_hit),
        .o_asg_rdata (asg_rdata),
        .o_vel_rdata (vel_rdata)
    );

    mtm_emitter u_emit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_clear        (clear),
        .i_start        (start),
        .i_plan         (plan),
        .i_pend         (r_pend),
        .o_busy         (emit_busy),
        .o_valid        (o_out_valid),
        .i_stall        (i_out_stall),
        .o_midi_byte    (o_midi_byte),
        .o_last         (o_last),
        .o_bad_score    (o_bad_score),
        .o_score_done   (o_score_done),
        .o_track_length (o_track_length)
    );

    // Next channel in allocation order, skipping the percussion channel.
    always_comb begin
        alloc_ch = r_best + 5'd1;
        if (alloc_ch == {1'b0, MIDI_PERC}) begin
            alloc_ch = alloc_ch + 5'd1;
        end
    end

    // Delay accumulation with saturation.
    always_comb begin
        if (r_acc > ACC_LIMIT) begin
            acc_next = TIME_MAX;
        end else begin
            acc_next = {r_acc[20:0], r_byte[6:0]};
        end
        pend_sum = {1'b0, r_pend} + {1'b0, acc_next};
    end

    assign cval = r_byte[7] ? 8'h7F : r_byte;

    // Evaluate one score byte: plan the events and update parse state.
    always_comb begin
        logic [1:0] slot;
        logic [3:0] ch;
        logic [3:0] evc;
        slot     = 2'd0;
        ch       = r_cur_ch;
        evc      = {1'b0, r_byte[6:4]};
        plan     = '0;
        asg_we   = 1'b0;
        vel_we   = 1'b0;
        n_phase  = r_phase;
        n_cur_ch = r_cur_ch;
        n_ge     = r_ge;
        n_key    = r_key;
        n_ctl    = r_ctl;
        n_acc    = r_acc;
        n_pend   = r_pend;
        n_best   = r_best;
        n_halt   = r_halt;
        if (eval) begin
            case (r_phase)
                PH_DESC: begin
                    n_ge = r_byte[7];
                    if (r_byte[3:0] == MUS_PERC) begin
                        ch = MIDI_PERC;
                    end else if (asg_hit) begin
                        ch = asg_rdata;
                    end else begin
                        ch          = alloc_ch[3:0];
                        asg_we      = 1'b1;
                        n_best      = alloc_ch;
                        plan.ev[0]  = mk_ev(ST_CTL | {4'h0, ch}, CC_NOTES_OFF, 8'h00, 1'b0);
                        slot        = 2'd1;
                    end
                    n_cur_ch = ch;
                    case (evc)
                        EV_REL:   n_phase = PH_KREL;
                        EV_PRESS: n_phase = PH_KPRESS;
                        EV_PITCH: n_phase = PH_PITCH;
                        EV_SYS:   n_phase = PH_SYS;
                        EV_CTL:   n_phase = PH_CNUM;
                        EV_END: begin
                            plan.ev[slot] = mk_ev(ST_META, META_EOT, 8'h00, 1'b0);
                            slot          = slot + 2'd1;
                            plan.done     = 1'b1;
                            n_phase       = PH_DONE;
                        end
                        default: begin
                            plan.err = 1'b1;
                            n_halt   = 1'b1;
                        end
                    endcase
                end
                PH_KREL: begin
                    n_key      = r_byte;
                    plan.ev[0] = mk_ev(ST_OFF | {4'h0, ch}, {1'b0, r_byte[6:0]}, 8'h00, 1'b0);
                    slot       = 2'd1;
                end
                PH_KPRESS: begin
                    n_key = r_byte;
                    if (r_byte[7]) begin
                        n_phase = PH_VEL;
                    end else begin
                        plan.ev[0] = mk_ev(ST_ON | {4'h0, ch}, {1'b0, r_byte[6:0]},
                                           {1'b0, vel_rdata}, 1'b0);
                        slot       = 2'd1;
                    end
                end
                PH_VEL: begin
                    vel_we     = 1'b1;
                    plan.ev[0] = mk_ev(ST_ON | {4'h0, ch}, {1'b0, r_key[6:0]},
                                       {1'b0, r_byte[6:0]}, 1'b0);
                    slot       = 2'd1;
                end
                PH_PITCH: begin
                    plan.ev[0] = mk_ev(ST_BEND | {4'h0, ch}, {1'b0, r_byte[0], 6'd0},
                                       {1'b0, r_byte[7:1]}, 1'b0);
                    slot       = 2'd1;
                end
                PH_SYS: begin
                    n_ctl = r_byte;
                    if (r_byte < SYS_LOW || r_byte > SYS_HIGH) begin
                        plan.err = 1'b1;
                        n_halt   = 1'b1;
                    end else if (r_byte == SYS_RESET && r_adlib) begin
                        plan.ev[0] = mk_ev(ST_CTL | {4'h0, ch}, CC_SOUND_OFF, 8'h00, 1'b0);
                        plan.ev[1] = mk_ev(ST_BEND | {4'h0, ch}, 8'h00, MID_VALUE, 1'b0);
                        plan.ev[2] = mk_ev(ST_CTL | {4'h0, ch}, CC_PAN, MID_VALUE, 1'b0);
                        slot       = 2'd3;
                    end else begin
                        plan.ev[0] = mk_ev(ST_CTL | {4'h0, ch}, ctl_map(r_byte[3:0]),
                                           8'h00, 1'b0);
                        slot       = 2'd1;
                    end
                end
                PH_CNUM: begin
                    n_ctl   = r_byte;
                    n_phase = PH_CVAL;
                end
                PH_CVAL: begin
                    if (r_ctl == 8'd0) begin
                        plan.ev[0] = mk_ev(ST_PROG | {4'h0, ch}, {1'b0, r_byte[6:0]},
                                           8'h00, 1'b1);
                        slot       = 2'd1;
                    end else if (r_ctl > CTL_HIGH) begin
                        plan.err = 1'b1;
                        n_halt   = 1'b1;
                    end else begin
                        plan.ev[0] = mk_ev(ST_CTL | {4'h0, ch}, ctl_map(r_ctl[3:0]),
                                           cval, 1'b0);
                        slot       = 2'd1;
                    end
                end
                PH_DELAY: begin
                    n_acc = acc_next;
                    if (!r_byte[7]) begin
                        n_pend  = pend_sum[28] ? TIME_MAX :
                                  (pend_sum[27:0] > TIME_MAX ? TIME_MAX : pend_sum[27:0]);
                        n_acc   = '0;
                        n_phase = PH_DESC;
                    end
                end
                default: begin
                end
            endcase
            // A completed event ends the group or moves on to the delay.
            if (slot != 2'd0 && r_phase != PH_DESC) begin
                n_acc   = '0;
                n_phase = r_ge ? PH_DELAY : PH_DESC;
            end
            if (slot != 2'd0) begin
                n_pend = '0;
            end
            plan.nev = slot;
        end
    end

    assign start = eval && ((plan.nev != 2'd0) || plan.err);

    // Control sequence.
    always_comb begin
        n_state = r_state;
        case (r_state)
            C_IDLE: if (accept) n_state = C_EVAL;
            C_EVAL: n_state = start ? C_EMIT : C_IDLE;
            C_EMIT: if (!emit_busy) n_state = C_IDLE;
            default: n_state = C_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_adlib <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_adlib <= i_cfg_wr_data;
        end
    end

    // Captured input word.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte <= i_score_byte;
        end
    end

    // Parse state; a new score clears the per-score part on acceptance.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_DESC;
            r_cur_ch <= '0;
            r_ge     <= 1'b0;
            r_key    <= '0;
            r_ctl    <= '0;
            r_acc    <= '0;
            r_pend   <= '0;
            r_best   <= NONE_ALLOC;
            r_halt   <= 1'b0;
        end else if (clear) begin
            r_phase <= PH_DESC;
            r_ge    <= 1'b0;
            r_acc   <= '0;
            r_best  <= NONE_ALLOC;
            r_halt  <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_cur_ch <= n_cur_ch;
            r_ge     <= n_ge;
            r_key    <= n_key;
            r_ctl    <= n_ctl;
            r_acc    <= n_acc;
            r_pend   <= n_pend;
            r_best   <= n_best;
            r_halt   <= n_halt;
        end
    end

`ifndef ASSERT_OFF
    // The control sequence always leaves evaluation in the next cycle.
    a_eval_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == C_EVAL) |=> (r_state != C_EVAL))
        else $error("evaluation repeated");

    // No new word is taken while the emitter still sends bytes.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> !emit_busy)
        else $error("input accepted during emission");

    // Queued time never exceeds its saturation limit.
    a_pend_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend <= TIME_MAX) && (r_acc <= TIME_MAX))
        else $error("delay above limit");
`endif

endmodule
